// ----- hw/rtl/bwm_pkg.sv -----
package bwm_pkg;

  // Fixed widths of the access fields.
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BANK_IDX_W = ADDR_W - 1;

  // Register window and memory sizing.
  localparam int unsigned REG_COUNT    = 8;
  localparam int unsigned REG_IDX_W    = $clog2(REG_COUNT);
  localparam int unsigned MEM_BYTES    = 65536;
  localparam int unsigned KIB_BYTES    = 1024;
  localparam int unsigned KIB_SHIFT    = $clog2(KIB_BYTES);
  localparam int unsigned KIB_W        = 7;
  localparam int unsigned LIMIT_W      = KIB_W + KIB_SHIFT;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_KIB       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_OUT_ADDRESS = 1'b1;
  localparam logic [KIB_W-1:0]     MEMORY_KIB_RST       = 7'd64;
  localparam logic [ADDR_W-1:0]    CHAR_OUT_ADDRESS_RST = 16'hFF76;

  typedef enum logic [1:0] {
    OP_BYTE_READ  = 2'd0,
    OP_BYTE_WRITE = 2'd1,
    OP_WORD_READ  = 2'd2,
    OP_WORD_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ODD   = 2'd2
  } status_e;

  // Which source forms the read data of a request.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_REG_BYTE,
    RD_REG_WORD,
    RD_MEM_BYTE,
    RD_MEM_WORD
  } rd_sel_e;

  // Decoded request: storage controls plus the result fields that are known at once.
  typedef struct packed {
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  reg_we;
    logic [DATA_W-1:0]     reg_wdata;
    logic [BANK_IDX_W-1:0] even_idx;
    logic [BANK_IDX_W-1:0] odd_idx;
    logic                  even_we;
    logic                  odd_we;
    logic [BYTE_W-1:0]     even_wdata;
    logic [BYTE_W-1:0]     odd_wdata;
    rd_sel_e               rd_sel;
    logic                  lo_odd;
    logic                  char_valid;
    logic [BYTE_W-1:0]     char_byte;
    status_e               status;
  } acc_t;

endpackage

// ----- hw/rtl/bwm_decode.sv -----
module bwm_decode import bwm_pkg::*; (
  input  logic [1:0]         opcode_i,
  input  logic [ADDR_W-1:0]  access_address_i,
  input  logic [DATA_W-1:0]  write_value_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  logic [ADDR_W-1:0]  char_out_address_i,
  output acc_t               acc_o
);

  logic [LIMIT_W-1:0] addr_ext;
  logic [LIMIT_W-1:0] addr_next;
  logic               byte_ok;
  logic               word_ok;
  logic               is_reg;
  logic               is_char;
  op_e                op;

  // Range checks against the usable limit, plus register-window and character-address matches.
  assign op        = op_e'(opcode_i);
  assign addr_ext  = LIMIT_W'(access_address_i);
  assign addr_next = addr_ext + LIMIT_W'(1);
  assign byte_ok   = addr_ext < limit_i;
  assign word_ok   = addr_next < limit_i;
  assign is_reg    = access_address_i < ADDR_W'(REG_COUNT);
  assign is_char   = access_address_i == char_out_address_i;

  always_comb begin
    acc_o            = '0;
    acc_o.rd_sel     = RD_NONE;
    acc_o.status     = ST_OK;
    acc_o.reg_idx    = access_address_i[REG_IDX_W-1:0];
    acc_o.reg_wdata  = write_value_i;
    acc_o.odd_idx    = access_address_i[ADDR_W-1:1];
    // An odd word read takes its high byte from the next even entry.
    acc_o.even_idx   = access_address_i[0] ? access_address_i[ADDR_W-1:1] + BANK_IDX_W'(1)
                                           : access_address_i[ADDR_W-1:1];
    acc_o.lo_odd     = access_address_i[0];
    acc_o.even_wdata = write_value_i[BYTE_W-1:0];
    acc_o.odd_wdata  = access_address_i[0] ? write_value_i[BYTE_W-1:0]
                                           : write_value_i[DATA_W-1:BYTE_W];

    if (is_reg) begin
      // Register window: no alignment, range or character handling.
      unique case (op)
        OP_BYTE_READ:  acc_o.rd_sel = RD_REG_BYTE;
        OP_BYTE_WRITE: begin
          acc_o.reg_we    = 1'b1;
          acc_o.reg_wdata = {{(DATA_W-BYTE_W){write_value_i[BYTE_W-1]}},
                             write_value_i[BYTE_W-1:0]};
        end
        OP_WORD_READ:  acc_o.rd_sel = RD_REG_WORD;
        OP_WORD_WRITE: acc_o.reg_we = 1'b1;
        default:       acc_o.rd_sel = RD_NONE;
      endcase
    end else begin
      unique case (op)
        OP_BYTE_READ: begin
          if (!byte_ok) acc_o.status = ST_RANGE;
          else          acc_o.rd_sel = RD_MEM_BYTE;
        end
        OP_BYTE_WRITE: begin
          priority if (is_char) begin
            acc_o.char_valid = 1'b1;
            acc_o.char_byte  = write_value_i[BYTE_W-1:0];
          end else if (!byte_ok) begin
            acc_o.status = ST_RANGE;
          end else begin
            acc_o.even_we = !access_address_i[0];
            acc_o.odd_we  = access_address_i[0];
          end
        end
        OP_WORD_READ: begin
          if (!word_ok) acc_o.status = ST_RANGE;
          else          acc_o.rd_sel = RD_MEM_WORD;
        end
        OP_WORD_WRITE: begin
          priority if (access_address_i[0]) begin
            acc_o.status = ST_ODD;
          end else if (is_char) begin
            acc_o.char_valid = 1'b1;
            acc_o.char_byte  = write_value_i[BYTE_W-1:0];
          end else if (!word_ok) begin
            acc_o.status = ST_RANGE;
          end else begin
            acc_o.even_we = 1'b1;
            acc_o.odd_we  = 1'b1;
          end
        end
        default: acc_o.rd_sel = RD_NONE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/bwm_regfile.sv -----
module bwm_regfile import bwm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 we_i,
  input  logic [REG_IDX_W-1:0] idx_i,
  input  logic [DATA_W-1:0]    wdata_i,
  output logic [DATA_W-1:0]    rdata_o
);

  logic [DATA_W-1:0] regs_q [REG_COUNT];
  logic [DATA_W-1:0] rdata_q;

  // Register storage, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= '0;
    end else if (en_i && we_i) begin
      regs_q[idx_i] <= wdata_i;
    end
  end

  // Read data is captured with the request.
  always_ff @(posedge clk_i) begin
    if (en_i) rdata_q <= regs_q[idx_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bwm_bank.sv -----
module bwm_bank #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Single-port byte bank with registered read data.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem[addr_i] <= wdata_i;
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/byte_word_memory_with_register_window.sv -----
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_stall_o    opcode_i, access_address_i, write_value_i
// out      out  out_valid_o / out_stall_i  read_value_o, char_valid_o, char_byte_o, status_o
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle while the input is not stalled; its result appears in the cycle after acceptance.
// The result comes from the registered read of the byte banks and the register file.
// Reset clears the register file and loads the configuration defaults; memory
// contents stay unknown until written.
// A stalled result holds, and a new request is taken only when the result slot is free
// or being drained in the same cycle.
module byte_word_memory_with_register_window import bwm_pkg::*; #(
  parameter int unsigned MEM_BYTES_P = MEM_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [ADDR_W-1:0]    access_address_i,
  input  logic [DATA_W-1:0]    write_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    read_value_o,
  output logic                 char_valid_o,
  output logic [BYTE_W-1:0]    char_byte_o,
  output logic [1:0]           status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned BANK_DEPTH = MEM_BYTES_P / 2;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
  localparam logic [LIMIT_W-1:0] MEM_LIMIT = LIMIT_W'(MEM_BYTES_P);

  logic [KIB_W-1:0]   memory_kib_q;
  logic [ADDR_W-1:0]  char_out_address_q;
  logic [LIMIT_W-1:0] kib_bytes;
  logic [LIMIT_W-1:0] limit;
  logic               in_accept;
  acc_t               acc;
  logic               res_valid_q;
  rd_sel_e            res_rd_sel_q;
  logic               res_lo_odd_q;
  logic               res_char_valid_q;
  logic [BYTE_W-1:0]  res_char_byte_q;
  status_e            res_status_q;
  logic [DATA_W-1:0]  reg_rdata;
  logic [BYTE_W-1:0]  even_rdata;
  logic [BYTE_W-1:0]  odd_rdata;
  logic [BYTE_W-1:0]  lo_byte;
  logic [BYTE_W-1:0]  hi_byte;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_kib_q       <= MEMORY_KIB_RST;
      char_out_address_q <= CHAR_OUT_ADDRESS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_MEMORY_KIB)       memory_kib_q       <= cfg_data_i[KIB_W-1:0];
      if (cfg_index_i == CFG_CHAR_OUT_ADDRESS) char_out_address_q <= cfg_data_i;
    end
  end

  // Usable limit, saturated at the physical memory size.
  assign kib_bytes = {memory_kib_q, KIB_SHIFT'(0)};
  assign limit     = (kib_bytes > MEM_LIMIT) ? MEM_LIMIT : kib_bytes;

  // Input handshake: take a request whenever the result slot frees up.
  assign in_stall_o = res_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  bwm_decode u_decode (
    .opcode_i           (opcode_i),
    .access_address_i   (access_address_i),
    .write_value_i      (write_value_i),
    .limit_i            (limit),
    .char_out_address_i (char_out_address_q),
    .acc_o              (acc)
  );

  bwm_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_accept),
    .we_i    (acc.reg_we),
    .idx_i   (acc.reg_idx),
    .wdata_i (acc.reg_wdata),
    .rdata_o (reg_rdata)
  );

  // Even and odd byte banks let an odd word read fetch both bytes at once.
  bwm_bank #(.DEPTH(BANK_DEPTH), .DW(BYTE_W)) u_bank_even (
    .clk_i   (clk_i),
    .en_i    (in_accept),
    .we_i    (acc.even_we),
    .addr_i  (acc.even_idx[BANK_AW-1:0]),
    .wdata_i (acc.even_wdata),
    .rdata_o (even_rdata)
  );

  bwm_bank #(.DEPTH(BANK_DEPTH), .DW(BYTE_W)) u_bank_odd (
    .clk_i   (clk_i),
    .en_i    (in_accept),
    .we_i    (acc.odd_we),
    .addr_i  (acc.odd_idx[BANK_AW-1:0]),
    .wdata_i (acc.odd_wdata),
    .rdata_o (odd_rdata)
  );

  // Result slot valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_accept) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result fields known at decode time.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_rd_sel_q     <= acc.rd_sel;
      res_lo_odd_q     <= acc.lo_odd;
      res_char_valid_q <= acc.char_valid;
      res_char_byte_q  <= acc.char_byte;
      res_status_q     <= acc.status;
    end
  end

  // Read data assembly from the registered storage outputs.
  assign lo_byte = res_lo_odd_q ? odd_rdata : even_rdata;
  assign hi_byte = res_lo_odd_q ? even_rdata : odd_rdata;

  always_comb begin
    unique case (res_rd_sel_q)
      RD_REG_BYTE: read_value_o = {BYTE_W'(0), reg_rdata[BYTE_W-1:0]};
      RD_REG_WORD: read_value_o = reg_rdata;
      RD_MEM_BYTE: read_value_o = {BYTE_W'(0), lo_byte};
      RD_MEM_WORD: read_value_o = {hi_byte, lo_byte};
      default:     read_value_o = '0;
    endcase
  end

  assign out_valid_o  = res_valid_q;
  assign char_valid_o = res_char_valid_q;
  assign char_byte_o  = res_char_byte_q;
  assign status_o     = res_status_q;

  // A stall on the input side only comes from a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // Every accepted request yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> out_valid_o)
    else $error("accepted request produced no result");

  // A character is only emitted by a request that completed without fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && char_valid_o) |-> (status_o == ST_OK))
    else $error("character emitted with a fault status");

  // A faulted request returns no read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (status_o != ST_OK)) |-> (read_value_o == '0))
    else $error("faulted request returned read data");

endmodule

// ----- tb/sv/byte_word_memory_with_register_window_tb.sv -----
module byte_word_memory_with_register_window_tb import bwm_pkg::*;;

  // One result of a request, as the block reports it.
  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              char_valid;
    logic [BYTE_W-1:0] char_byte;
    status_e           status;
  } access_result_t;

  typedef enum logic {
    ROW_ACCESS,
    ROW_CONFIG
  } row_kind_e;

  // One line of the directed stimulus table.
  typedef struct {
    row_kind_e            kind;
    op_e                  op;
    logic [ADDR_W-1:0]    adr;
    logic [DATA_W-1:0]    data;
    logic [CFG_IDX_W-1:0] cfg_idx;
    bit                   typed;
    access_result_t       want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           opcode = 2'd0;
  logic [ADDR_W-1:0]    address = '0;
  logic [DATA_W-1:0]    wdata = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    read_value;
  logic                 char_valid;
  logic [BYTE_W-1:0]    char_byte;
  logic [1:0]           status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // Shadow copy of the block's state and configuration.
  logic [DATA_W-1:0] reg_image [REG_COUNT];
  logic [BYTE_W-1:0] mem_image [MEM_BYTES];
  bit                mem_written [MEM_BYTES];
  logic [KIB_W-1:0]  mem_kib;
  logic [ADDR_W-1:0] char_addr;

  access_result_t pending_results [$];
  row_t           dir_rows [$];
  int             mismatches = 0;
  int             hold_request = 0;
  int             hold_left = 0;
  bit             sender_idle_on = 1'b1;
  bit             recv_idle_on = 1'b1;

  byte_word_memory_with_register_window u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .access_address_i (address),
    .write_value_i    (wdata),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_value_o     (read_value),
    .char_valid_o     (char_valid),
    .char_byte_o      (char_byte),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Usable memory size in bytes, saturated at the physical size.
  function automatic int unsigned usable_limit();
    int unsigned lim;
    lim = int'(mem_kib) * KIB_BYTES;
    if (lim > MEM_BYTES) lim = MEM_BYTES;
    return lim;
  endfunction

  // Applies one request to the shadow state and returns its result.
  function automatic access_result_t apply_access(op_e op, logic [ADDR_W-1:0] adr,
                                                  logic [DATA_W-1:0] val);
    access_result_t res;
    int unsigned    lim;
    int unsigned    nxt;
    res = '{16'h0000, 1'b0, 8'h00, ST_OK};
    lim = usable_limit();
    nxt = int'(adr) + 1;
    if (adr < REG_COUNT) begin
      case (op)
        OP_BYTE_READ:  res.read_value = {8'h00, reg_image[adr[REG_IDX_W-1:0]][7:0]};
        OP_BYTE_WRITE: reg_image[adr[REG_IDX_W-1:0]] = {{8{val[7]}}, val[7:0]};
        OP_WORD_READ:  res.read_value = reg_image[adr[REG_IDX_W-1:0]];
        default:       reg_image[adr[REG_IDX_W-1:0]] = val;
      endcase
    end else begin
      case (op)
        OP_BYTE_READ: begin
          if (adr >= lim) res.status = ST_RANGE;
          else res.read_value = {8'h00, mem_image[adr]};
        end
        OP_BYTE_WRITE: begin
          if (adr == char_addr) begin
            res.char_valid = 1'b1;
            res.char_byte  = val[7:0];
          end else if (adr >= lim) begin
            res.status = ST_RANGE;
          end else begin
            mem_image[adr]   = val[7:0];
            mem_written[adr] = 1'b1;
          end
        end
        OP_WORD_READ: begin
          if (nxt >= lim) res.status = ST_RANGE;
          else res.read_value = {mem_image[nxt[15:0]], mem_image[adr]};
        end
        default: begin
          if (adr[0]) begin
            res.status = ST_ODD;
          end else if (adr == char_addr) begin
            res.char_valid = 1'b1;
            res.char_byte  = val[7:0];
          end else if (nxt >= lim) begin
            res.status = ST_RANGE;
          end else begin
            mem_image[adr]          = val[7:0];
            mem_image[nxt[15:0]]    = val[15:8];
            mem_written[adr]        = 1'b1;
            mem_written[nxt[15:0]]  = 1'b1;
          end
        end
      endcase
    end
    return res;
  endfunction

  // True when a read would fetch a memory byte that was never stored.
  function automatic bit reads_unwritten(op_e op, logic [ADDR_W-1:0] adr);
    int unsigned lim;
    int unsigned nxt;
    lim = usable_limit();
    nxt = int'(adr) + 1;
    if (adr < REG_COUNT) return 1'b0;
    if (op == OP_BYTE_READ) return adr < lim && !mem_written[adr];
    if (op == OP_WORD_READ) return nxt < lim && (!mem_written[adr] || !mem_written[nxt[15:0]]);
    return 1'b0;
  endfunction

  // Addresses cluster where the decode has its corners.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 18) return 16'($urandom_range(0, REG_COUNT - 1));
    if (roll < 28) return char_addr + 16'($urandom_range(0, 2)) - 16'd1;
    if (roll < 40) return 16'(usable_limit() - 2 + $urandom_range(0, 3));
    if (roll < 50) return 16'(REG_COUNT + $urandom_range(0, 7));
    if (roll < 85) return 16'h0100 + 16'($urandom_range(0, 47));
    return 16'($urandom);
  endfunction

  function automatic row_t plain_access(op_e op, logic [ADDR_W-1:0] adr,
                                        logic [DATA_W-1:0] val);
    row_t row;
    row.kind    = ROW_ACCESS;
    row.op      = op;
    row.adr     = adr;
    row.data    = val;
    row.cfg_idx = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic row_t known_access(op_e op, logic [ADDR_W-1:0] adr,
                                        logic [DATA_W-1:0] val, logic [DATA_W-1:0] rd,
                                        logic cv, logic [BYTE_W-1:0] cb, status_e st);
    row_t row;
    row       = plain_access(op, adr, val);
    row.typed = 1'b1;
    row.want  = '{rd, cv, cb, st};
    return row;
  endfunction

  function automatic row_t register_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    row_t row;
    row         = plain_access(OP_BYTE_READ, '0, val);
    row.kind    = ROW_CONFIG;
    row.cfg_idx = idx;
    return row;
  endfunction

  // Offers one request, waits until it is taken, then records its result.
  task automatic send_access(input op_e op, input logic [ADDR_W-1:0] adr,
                             input logic [DATA_W-1:0] val, input bit typed,
                             input access_result_t typed_res);
    access_result_t model_res;
    in_valid <= 1'b1;
    opcode   <= op;
    address  <= adr;
    wdata    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_res = apply_access(op, adr, val);
    pending_results.push_back(typed ? typed_res : model_res);
    if (sender_idle_on && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 36);
    end
  endtask

  // Stops offering requests and waits for every outstanding result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes one configuration register; the caller lowers the valid afterward.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MEMORY_KIB) mem_kib = val[KIB_W-1:0];
    else char_addr = val;
  endtask

  // Result checking and output stall generation, including the long hold-off.
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: expected no result, got read_value %h status %0d", $time, read_value,
                 status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.read_value) begin
          $display("%0t: read_value expected %h got %h", $time, want.read_value, read_value);
          mismatches++;
        end
        if (char_valid !== want.char_valid) begin
          $display("%0t: char_valid expected %b got %b", $time, want.char_valid, char_valid);
          mismatches++;
        end
        if (char_byte !== want.char_byte) begin
          $display("%0t: char_byte expected %h got %h", $time, want.char_byte, char_byte);
          mismatches++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
          mismatches++;
        end
      end
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (recv_idle_on) begin
      out_stall <= ($urandom_range(0, 99) < 36);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    op_e               op;
    logic [ADDR_W-1:0] adr;
    logic [DATA_W-1:0] val;
    logic [KIB_W-1:0]  kib;
    logic [ADDR_W-1:0] chr;

    foreach (reg_image[i]) reg_image[i] = '0;
    foreach (mem_written[i]) mem_written[i] = 1'b0;
    mem_kib   = MEMORY_KIB_RST;
    char_addr = CHAR_OUT_ADDRESS_RST;

    // Register window: reset contents, sign extension, word access at an odd index.
    dir_rows.push_back(known_access(OP_WORD_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(known_access(OP_BYTE_READ, 16'h0007, 16'hFFFF, 16'h0000, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(known_access(OP_BYTE_WRITE, 16'h0001, 16'h0080, 16'h0000, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(known_access(OP_WORD_READ, 16'h0001, 16'h0000, 16'hFF80, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(plain_access(OP_BYTE_WRITE, 16'h0002, 16'hFF7F));
    dir_rows.push_back(known_access(OP_WORD_READ, 16'h0002, 16'h0000, 16'h007F, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(plain_access(OP_WORD_WRITE, 16'h0007, 16'hFFFF));
    dir_rows.push_back(known_access(OP_BYTE_READ, 16'h0007, 16'h0000, 16'h00FF, 1'b0, 8'h00,
                                    ST_OK));
    // Little-endian memory, top byte, alignment and character output.
    dir_rows.push_back(plain_access(OP_WORD_WRITE, 16'h0008, 16'hA55A));
    dir_rows.push_back(known_access(OP_WORD_READ, 16'h0008, 16'h0000, 16'hA55A, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(known_access(OP_BYTE_READ, 16'h0009, 16'h0000, 16'h00A5, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(plain_access(OP_BYTE_WRITE, 16'hFFFF, 16'h1234));
    dir_rows.push_back(known_access(OP_BYTE_READ, 16'hFFFF, 16'h0000, 16'h0034, 1'b0, 8'h00,
                                    ST_OK));
    dir_rows.push_back(known_access(OP_WORD_READ, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 8'h00,
                                    ST_RANGE));
    dir_rows.push_back(known_access(OP_WORD_WRITE, 16'h000B, 16'h1111, 16'h0000, 1'b0, 8'h00,
                                    ST_ODD));
    dir_rows.push_back(known_access(OP_WORD_WRITE, 16'hFF77, 16'h2222, 16'h0000, 1'b0, 8'h00,
                                    ST_ODD));
    dir_rows.push_back(known_access(OP_BYTE_WRITE, 16'hFF76, 16'hABCD, 16'h0000, 1'b1, 8'hCD,
                                    ST_OK));
    dir_rows.push_back(known_access(OP_WORD_WRITE, 16'hFF76, 16'h1241, 16'h0000, 1'b1, 8'h41,
                                    ST_OK));
    // Smallest non-empty memory: range checks, odd word read crossing the limit.
    dir_rows.push_back(register_write(CFG_MEMORY_KIB, 16'd1));
    dir_rows.push_back(known_access(OP_BYTE_READ, 16'h0400, 16'h0000, 16'h0000, 1'b0, 8'h00,
                                    ST_RANGE));
    dir_rows.push_back(plain_access(OP_WORD_WRITE, 16'h03FE, 16'hBEEF));
    dir_rows.push_back(known_access(OP_WORD_READ, 16'h03FF, 16'h0000, 16'h0000, 1'b0, 8'h00,
                                    ST_RANGE));
    dir_rows.push_back(known_access(OP_BYTE_WRITE, 16'hFF76, 16'h0099, 16'h0000, 1'b1, 8'h99,
                                    ST_OK));
    // No memory at all, and a character address inside the register window.
    dir_rows.push_back(register_write(CFG_MEMORY_KIB, 16'd0));
    dir_rows.push_back(register_write(CFG_CHAR_OUT_ADDRESS, 16'h0003));
    dir_rows.push_back(known_access(OP_BYTE_READ, 16'h0008, 16'h0000, 16'h0000, 1'b0, 8'h00,
                                    ST_RANGE));
    dir_rows.push_back(plain_access(OP_BYTE_WRITE, 16'h0003, 16'h0081));
    dir_rows.push_back(known_access(OP_WORD_READ, 16'h0003, 16'h0000, 16'hFF81, 1'b0, 8'h00,
                                    ST_OK));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CONFIG) drain_results();
        set_register(dir_rows[i].cfg_idx, dir_rows[i].data);
        if (i == dir_rows.size() - 1 || dir_rows[i+1].kind != ROW_CONFIG) cfg_valid <= 1'b0;
      end else begin
        send_access(dir_rows[i].op, dir_rows[i].adr, dir_rows[i].data, dir_rows[i].typed,
                    dir_rows[i].want);
      end
    end

    // Random phases, each under its own memory size and character address.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin kib = 7'd64;  chr = CHAR_OUT_ADDRESS_RST; end
        1: begin kib = 7'd1;   chr = 16'h0200; end
        2: begin kib = 7'd127; chr = 16'hFFFF; end
        3: begin kib = 7'd0;   chr = 16'h0008; end
        4: begin kib = 7'($urandom_range(2, 63)); chr = 16'($urandom); end
        5: begin kib = 7'd64;  chr = 16'h0005; end
        default: begin kib = 7'd32; chr = 16'h0100 + 16'(2 * $urandom_range(0, 23)); end
      endcase
      drain_results();
      set_register(CFG_MEMORY_KIB, {9'($urandom), kib});
      set_register(CFG_CHAR_OUT_ADDRESS, chr);
      cfg_valid <= 1'b0;
      // One phase runs without any idling; the first one holds off the output for long.
      sender_idle_on = (p != 4) && (p != 0);
      recv_idle_on   = (p != 4);
      if (p == 0) hold_request = 40;
      repeat (80) begin
        op  = op_e'($urandom_range(0, 3));
        adr = pick_address();
        case ($urandom_range(0, 9))
          0:       val = 16'hFFFF;
          1:       val = 16'h0000;
          default: val = 16'($urandom);
        endcase
        if (reads_unwritten(op, adr)) op = op_e'(op | 2'd1);
        send_access(op, adr, val, 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Run time limit.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bwm_pkg.sv
hw/rtl/bwm_decode.sv
hw/rtl/bwm_regfile.sv
hw/rtl/bwm_bank.sv
hw/rtl/byte_word_memory_with_register_window.sv
tb/sv/byte_word_memory_with_register_window_tb.sv
